### sv/kri_pkg.sv
// ----------------------------------------------------------------------------
// kri_pkg
// Shared widths, constants and types of the keyframe rotation interpolator.
// ----------------------------------------------------------------------------
package kri_pkg;

    localparam int KEY_SLOTS   = 4;
    localparam int STAGES_DEF  = 4;
    localparam int TIME_W      = 16;
    localparam int ANG_W       = 24;
    localparam int LIFE_W      = 24;
    localparam int RAD_W       = 27;
    localparam int AGE_QW      = 16;
    localparam int DIV_W       = 25;
    localparam int IDX_W       = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int REG_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int K_W         = 28;
    localparam int PROD_W      = ANG_W + K_W - 1;

    localparam logic [TIME_W:0]  ONE_Q15        = 17'd32768;
    localparam logic [K_W-1:0]   DEG_TO_RAD_Q32 = 28'd74961321;
    localparam logic [TIME_W-1:0] KEY_TIME_RST  = 16'd32768;
    localparam logic [ANG_W-1:0]  KEY_ANGLE_RST = 24'd0;

    localparam logic [2:0] REG_KEY_ANGLE_BASE = 3'd4;

    typedef enum logic [1:0] {
        SEL_FIRST,
        SEL_LAST,
        SEL_SEG,
        SEL_NONE
    } sel_t;

    typedef struct packed {
        sel_t              sel;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] off;
        logic              bad;
    } job_t;

    typedef logic [KEY_SLOTS-1:0][TIME_W-1:0] key_time_t;
    typedef logic [KEY_SLOTS-1:0][ANG_W-1:0]  key_angle_t;

endpackage

### sv/keyframe_rotation_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_rotation_interpolator
// Piecewise linear rotation over up to four key times, per particle.
// ----------------------------------------------------------------------------
// Input stream s_*: one item per particle, tdata = {life_total, life_left}.
// Output stream m_*: tdata = {angle_radians, angle_degrees}, tuser = bad_life.
// The user must write key times and angles over the APB port only while the
// block is idle; the block itself does not enforce this. Throughput is one
// item per clock while the receiver does not stall: the age divider (16
// stages) and the interpolation divider (25 stages) each resolve one quotient
// bit per stage. A four-entry queue separates the classification front from
// the arithmetic back, so the front keeps accepting while the back is held.
// When m_tvalid is high and m_tready is low the back pipeline holds; once the
// queue fills, s_tready drops. Reset empties both pipelines and the queue and
// sets every key time to 1.0 and every key angle to zero.
// ----------------------------------------------------------------------------
module keyframe_rotation_interpolator import kri_pkg::*; #(
    parameter int STAGES = STAGES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // life_left, life_total
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [55:0]           m_tdata,   // angle_degrees, angle_radians, zero pad
    output logic                  m_tuser,   // bad_life
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    key_time_t  key_time_reg;
    key_angle_t key_angle_reg;
    logic [2:0] reg_idx;
    logic       cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[REG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_time_reg  <= {KEY_SLOTS{KEY_TIME_RST}};
            key_angle_reg <= {KEY_SLOTS{KEY_ANGLE_RST}};
        end else if (cfg_wr) begin
            if (reg_idx < REG_KEY_ANGLE_BASE) begin
                key_time_reg[reg_idx[IDX_W-1:0]] <= pwdata[TIME_W-1:0];
            end else begin
                key_angle_reg[reg_idx[IDX_W-1:0]] <= pwdata[ANG_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_idx < REG_KEY_ANGLE_BASE) begin
            prdata = APB_DATA_W'(key_time_reg[reg_idx[IDX_W-1:0]]);
        end else begin
            prdata = APB_DATA_W'($signed(key_angle_reg[reg_idx[IDX_W-1:0]]));
        end
    end

    logic job_valid, job_ready, q_valid, q_pop;
    job_t job, q_job;

    logic signed [ANG_W-1:0] angle_degrees;
    logic signed [RAD_W-1:0] angle_radians;

    kri_front #(.STAGES(STAGES)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .life_left  (s_tdata[23:0]),
        .life_total (s_tdata[47:24]),
        .key_time   (key_time_reg),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job)
    );

    kri_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (job_valid),
        .wr_ready (job_ready),
        .wr_job   (job),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_job   (q_job)
    );

    kri_back #(.STAGES(STAGES)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (q_valid),
        .job_pop       (q_pop),
        .job           (q_job),
        .key_time      (key_time_reg),
        .key_angle     (key_angle_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .angle_degrees (angle_degrees),
        .angle_radians (angle_radians),
        .bad_life      (m_tuser)
    );

    assign m_tdata = {5'b0, angle_radians, angle_degrees};

endmodule

### sv/kri_front.sv
// ----------------------------------------------------------------------------
// kri_front
// Age divider pipeline and segment classification.
// ----------------------------------------------------------------------------
module kri_front import kri_pkg::*; #(
    parameter int STAGES = STAGES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [LIFE_W-1:0] life_left,
    input  logic [LIFE_W-1:0] life_total,
    input  key_time_t         key_time,
    output logic              job_valid,
    input  logic              job_ready,
    output job_t              job
);

    localparam int N = AGE_QW;

    logic              adv;
    logic [N:0]        v_reg;
    logic [LIFE_W-1:0] rem_reg [0:N];
    logic [LIFE_W-1:0] tot_reg [0:N];
    logic [N-1:0]      q_reg   [0:N];
    logic              bad_reg [0:N];
    logic              neg_reg [0:N];

    assign adv      = !v_reg[N] || job_ready;
    assign in_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[N-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            bad_reg[0] <= (life_total == '0);
            neg_reg[0] <= (life_left > life_total);
            tot_reg[0] <= life_total;
            rem_reg[0] <= (life_left > life_total) ? '0 : life_left;
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_div
        logic [LIFE_W:0] sh;
        logic            ge;
        always_comb begin
            sh = (k == 0) ? {1'b0, rem_reg[k]} : {rem_reg[k], 1'b0};
            ge = (sh >= {1'b0, tot_reg[k]});
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k+1] <= ge ? LIFE_W'(sh - {1'b0, tot_reg[k]}) : LIFE_W'(sh);
                tot_reg[k+1] <= tot_reg[k];
                q_reg[k+1]   <= {q_reg[k][N-2:0], ge};
                bad_reg[k+1] <= bad_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    logic [TIME_W:0]   age_w;
    logic [TIME_W-1:0] age;

    always_comb begin
        age_w   = ONE_Q15 - {1'b0, q_reg[N]};
        age     = age_w[TIME_W-1:0];
        job.bad = bad_reg[N];
        job.idx = '0;
        job.off = '0;
        if (bad_reg[N] || neg_reg[N] || age <= key_time[0]) begin
            job.sel = SEL_FIRST;
        end else if (age >= key_time[STAGES-1]) begin
            job.sel = SEL_LAST;
        end else begin
            job.sel = SEL_NONE;
            for (int i = STAGES - 2; i >= 0; i--) begin
                if (age >= key_time[i] && age < key_time[i+1]) begin
                    job.sel = SEL_SEG;
                    job.idx = IDX_W'(i);
                    job.off = age - key_time[i];
                end
            end
        end
    end

    assign job_valid = v_reg[N];

endmodule

### sv/kri_queue.sv
// ----------------------------------------------------------------------------
// kri_queue
// Short queue between the classification front and the arithmetic back.
// ----------------------------------------------------------------------------
module kri_queue import kri_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_job,
    output logic rd_valid,
    input  logic rd_pop,
    output job_t rd_job
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    job_t          mem_reg [0:QUEUE_DEPTH-1];
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic          push;

    assign wr_ready = (cnt_reg != (PW+1)'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign rd_job   = mem_reg[rp_reg];

    always_comb begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = rd_pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(rd_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= wr_job;
        end
    end

endmodule

### sv/kri_back.sv
// ----------------------------------------------------------------------------
// kri_back
// Interpolation multiply, rounding divider and degree-to-radian scaling.
// ----------------------------------------------------------------------------
module kri_back import kri_pkg::*; #(
    parameter int STAGES = STAGES_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    job_valid,
    output logic                    job_pop,
    input  job_t                    job,
    input  key_time_t               key_time,
    input  key_angle_t              key_angle,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [ANG_W-1:0] angle_degrees,
    output logic signed [RAD_W-1:0] angle_radians,
    output logic                    bad_life
);

    localparam int ND     = DIV_W;
    localparam int MAG_W  = DIV_W + TIME_W;
    localparam int NUM_W  = MAG_W + 1;
    localparam int NSTAGE = ND + 6;

    logic              adv;
    logic [NSTAGE-1:0] v_reg;

    assign adv     = !v_reg[NSTAGE-1] || out_ready;
    assign job_pop = adv && job_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NSTAGE-2:0], job_valid};
        end
    end

    // stage 0: fetch keys
    logic [IDX_W-1:0]        idx1;
    logic signed [ANG_W:0]   diff;
    logic signed [ANG_W-1:0] base;

    always_comb begin
        idx1 = job.idx + IDX_W'(1);
        diff = $signed({key_angle[idx1][ANG_W-1], key_angle[idx1]})
             - $signed({key_angle[job.idx][ANG_W-1], key_angle[job.idx]});
        unique case (job.sel)
            SEL_FIRST: base = $signed(key_angle[0]);
            SEL_LAST:  base = $signed(key_angle[STAGES-1]);
            SEL_SEG:   base = $signed(key_angle[job.idx]);
            default:   base = '0;
        endcase
    end

    logic signed [ANG_W-1:0] s0_base_reg;
    logic [DIV_W-1:0]        s0_absd_reg;
    logic [TIME_W-1:0]       s0_off_reg, s0_d_reg;
    logic                    s0_neg_reg, s0_seg_reg, s0_bad_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_base_reg <= base;
            s0_absd_reg <= diff[ANG_W] ? DIV_W'(-diff) : DIV_W'(diff);
            s0_off_reg  <= job.off;
            s0_d_reg    <= key_time[idx1] - key_time[job.idx];
            s0_neg_reg  <= diff[ANG_W];
            s0_seg_reg  <= (job.sel == SEL_SEG);
            s0_bad_reg  <= job.bad;
        end
    end

    // stage 1: magnitude of the numerator
    logic signed [ANG_W-1:0] s1_base_reg;
    logic [MAG_W-1:0]        s1_mag_reg;
    logic [TIME_W-1:0]       s1_d_reg;
    logic                    s1_neg_reg, s1_seg_reg, s1_bad_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_base_reg <= s0_base_reg;
            s1_mag_reg  <= s0_absd_reg * s0_off_reg;
            s1_d_reg    <= s0_d_reg;
            s1_neg_reg  <= s0_neg_reg;
            s1_seg_reg  <= s0_seg_reg;
            s1_bad_reg  <= s0_bad_reg;
        end
    end

    // stage 2 onward: restoring divider, one quotient bit per stage
    logic [NUM_W-1:0]        num;
    logic [TIME_W-1:0]       rem_reg  [0:ND];
    logic [ND-1:0]           low_reg  [0:ND];
    logic [ND-1:0]           q_reg    [0:ND];
    logic [TIME_W-1:0]       d_reg    [0:ND];
    logic signed [ANG_W-1:0] base_reg [0:ND];
    logic                    neg_reg  [0:ND];
    logic                    seg_reg  [0:ND];
    logic                    bad_reg  [0:ND];

    assign num = {1'b0, s1_mag_reg} + NUM_W'(s1_d_reg >> 1);

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0]  <= num[NUM_W-2:ND];
            low_reg[0]  <= num[ND-1:0];
            q_reg[0]    <= '0;
            d_reg[0]    <= s1_d_reg;
            base_reg[0] <= s1_base_reg;
            neg_reg[0]  <= s1_neg_reg;
            seg_reg[0]  <= s1_seg_reg;
            bad_reg[0]  <= s1_bad_reg;
        end
    end

    for (genvar j = 0; j < ND; j++) begin : g_div
        logic [TIME_W:0] sh;
        logic            ge;
        always_comb begin
            sh = {rem_reg[j], low_reg[j][ND-1]};
            ge = (sh >= {1'b0, d_reg[j]});
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[j+1]  <= ge ? TIME_W'(sh - {1'b0, d_reg[j]}) : TIME_W'(sh);
                low_reg[j+1]  <= {low_reg[j][ND-2:0], 1'b0};
                q_reg[j+1]    <= {q_reg[j][ND-2:0], ge};
                d_reg[j+1]    <= d_reg[j];
                base_reg[j+1] <= base_reg[j];
                neg_reg[j+1]  <= neg_reg[j];
                seg_reg[j+1]  <= seg_reg[j];
                bad_reg[j+1]  <= bad_reg[j];
            end
        end
    end

    // add the interpolated step to the base key angle
    logic signed [ANG_W:0]   step;
    logic signed [ANG_W:0]   deg_w;
    logic signed [ANG_W-1:0] e_deg_reg;
    logic                    e_bad_reg;

    always_comb begin
        step = seg_reg[ND] ? (neg_reg[ND] ? -$signed(q_reg[ND]) : $signed(q_reg[ND])) : '0;
        deg_w = $signed({base_reg[ND][ANG_W-1], base_reg[ND]}) + step;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_deg_reg <= deg_w[ANG_W-1:0];
            e_bad_reg <= bad_reg[ND];
        end
    end

    // scale to radians
    logic signed [ANG_W-1:0]  f_deg_reg;
    logic signed [PROD_W-1:0] f_prod_reg;
    logic                     f_bad_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_deg_reg  <= e_deg_reg;
            f_prod_reg <= PROD_W'(e_deg_reg * $signed(DEG_TO_RAD_Q32));
            f_bad_reg  <= e_bad_reg;
        end
    end

    // round to nearest, halves away from zero
    logic [PROD_W-1:0] pmag;
    logic [PROD_W-1:0] pr;
    logic [RAD_W-1:0]  rmag;

    always_comb begin
        pmag = f_prod_reg[PROD_W-1] ? PROD_W'(-f_prod_reg) : PROD_W'(f_prod_reg);
        pr   = (pmag + (PROD_W'(1) << 23)) >> 24;
        rmag = pr[RAD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            angle_degrees <= f_deg_reg;
            angle_radians <= f_prod_reg[PROD_W-1] ? $signed(-rmag) : $signed(rmag);
            bad_life      <= f_bad_reg;
        end
    end

    assign out_valid = v_reg[NSTAGE-1];

endmodule

### sv/kri_checker.sv
// ----------------------------------------------------------------------------
// kri_checker
// Port-level checks of the keyframe rotation interpolator.
// ----------------------------------------------------------------------------
module kri_checker import kri_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [47:0]           s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [55:0]           m_tdata,
    input logic                  m_tuser,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [REG_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_zero_rad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[23:0] == 24'd0 |-> m_tdata[50:24] == 27'd0)
        else $error("nonzero radians for zero degrees");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind keyframe_rotation_interpolator kri_checker u_kri_checker (.*);
